// ===== rtl/lifo_fr_pkg.sv =====
// Shared types, constants and helpers for the LIFO stack with find and replace.
`default_nettype none
package lifo_fr_pkg;

   // Storage geometry
   localparam int DEPTH        = 64;
   localparam int DATA_WIDTH   = 32;
   localparam int IN_WIDTH     = 32;
   localparam int COUNT_WIDTH  = $clog2(DEPTH + 1);
   localparam int SCAN_WIDTH   = $clog2(DEPTH);
   localparam int ENTRY_CNT_W  = 7;

   typedef logic [DATA_WIDTH-1:0] word_type;

   // Command codes
   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_FIND  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   // Status codes
   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_EMPTY     = 2'd1,
      STS_FULL      = 2'd2,
      STS_NOT_FOUND = 2'd3
   } status_type;

   // Per-cycle move of every cell in the chain
   typedef enum logic [1:0] {
      OP_HOLD       = 2'd0,
      OP_SHIFT_DOWN = 2'd1,
      OP_SHIFT_UP   = 2'd2
   } cell_op_type;

   // Control bundle from the controller to the cell chain
   typedef struct packed {
      cell_op_type op;
      word_type    push_word;
      word_type    wrap_word;
   } cell_ctl_type;

   // Sign-extend a 32-bit input word and keep its low DATA_WIDTH bits
   function automatic word_type to_word(input logic [IN_WIDTH-1:0] raw);
      logic signed [63:0] ext;
      ext = 64'(signed'(raw));
      return ext[DATA_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/lifo_fr_cell.sv =====
// One storage cell of the stack chain: holds one word, loads from a neighbor.
`default_nettype none
module lifo_fr_cell (
   input  wire logic                   clock,
   input  wire lifo_fr_pkg::cell_ctl_type ctl,
   input  wire lifo_fr_pkg::word_type  upper_word,
   input  wire lifo_fr_pkg::word_type  lower_word,
   output      lifo_fr_pkg::word_type  q_word
);
   import lifo_fr_pkg::*;

   word_type word_ff;
   word_type word_in;

   // Select next content: keep, take the newer neighbor, or take the older one
   always_comb begin
      case (ctl.op)
         OP_SHIFT_DOWN: word_in = upper_word;
         OP_SHIFT_UP:   word_in = lower_word;
         default:       word_in = word_ff;
      endcase
   end

   // Payload register, no reset: content is undefined until pushed
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign q_word = word_ff;

endmodule
`default_nettype wire

// ===== rtl/lifo_fr_ctrl.sv =====
// Command sequencer: handshakes, fill count, find scan and result register.
`default_nettype none
module lifo_fr_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_stall,
   input  wire logic [1:0]                  req_command,
   input  wire logic [31:0]                 req_value,
   input  wire logic [31:0]                 req_match_value,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   output      logic [1:0]                  rsp_status,
   output      logic [6:0]                  rsp_entry_count,
   input  wire lifo_fr_pkg::word_type       top_word,
   output      lifo_fr_pkg::cell_ctl_type   cell_ctl
);
   import lifo_fr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type              state_ff, state_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [SCAN_WIDTH-1:0]  scan_ff, scan_in;
   logic                   found_ff, found_in;
   word_type               match_ff, match_in;
   word_type               repl_ff, repl_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [ENTRY_CNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic    accept;
   logic    rsp_load;
   logic    in_range;
   logic    hit;
   logic    last_step;
   cmd_type cmd;

   // Handshake: one item at a time, result register must be free or draining
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign cmd       = cmd_type'(req_command);

   // Scan compare at the top cell; the chain rotates one place each cycle
   assign in_range  = COUNT_WIDTH'(scan_ff) < count_ff;
   assign hit       = (state_ff == ST_SCAN) && !found_ff && in_range && (top_word == match_ff);
   assign last_step = scan_ff == SCAN_WIDTH'(DEPTH - 1);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      found_in      = found_ff;
      match_in      = match_ff;
      repl_in       = repl_ff;
      rsp_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      cell_ctl.op        = OP_HOLD;
      cell_ctl.push_word = to_word(req_value);
      cell_ctl.wrap_word = hit ? repl_ff : top_word;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd)
                  CMD_PUSH: begin
                     rsp_load = 1'b1;
                     if (count_ff == COUNT_WIDTH'(DEPTH)) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        rsp_status_in = STS_OK;
                        cell_ctl.op   = OP_SHIFT_DOWN;
                        count_in      = count_ff + COUNT_WIDTH'(1);
                     end
                  end
                  CMD_POP: begin
                     rsp_load = 1'b1;
                     if (count_ff == '0) begin
                        rsp_status_in = STS_EMPTY;
                     end else begin
                        rsp_status_in = STS_OK;
                        cell_ctl.op   = OP_SHIFT_UP;
                        count_in      = count_ff - COUNT_WIDTH'(1);
                     end
                  end
                  CMD_FIND: begin
                     match_in = to_word(req_match_value);
                     repl_in  = to_word(req_value);
                     scan_in  = '0;
                     found_in = 1'b0;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     rsp_load      = 1'b1;
                     rsp_status_in = STS_OK;
                     count_in      = '0;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Full rotation restores the original order after DEPTH steps
            cell_ctl.op = OP_SHIFT_UP;
            found_in    = found_ff || hit;
            scan_in     = scan_ff + SCAN_WIDTH'(1);
            if (last_step) begin
               rsp_load      = 1'b1;
               rsp_status_in = (found_ff || hit) ? STS_OK : STS_NOT_FOUND;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register
   assign rsp_count_in = ENTRY_CNT_W'(count_in);
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff  <= scan_in;
      match_ff <= match_in;
      repl_ff  <= repl_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(DEPTH))
      else $error("fill count above depth");

   a_scan_count_stable: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |=> $stable(count_ff))
      else $error("fill count moved during scan");

   a_found_sticky: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && found_ff && !last_step |=> found_ff)
      else $error("found flag dropped during scan");

   a_scan_no_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> !accept && !(rsp_load && !last_step))
      else $error("item taken or result loaded mid-scan");

   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_status_ff))
      else $error("pending result lost");

endmodule
`default_nettype wire

// ===== rtl/lifo_stack_with_find_replace_core.sv =====
// Top level: controller plus the chain of storage cells.
`default_nettype none
// Bounded LIFO of DEPTH signed words held in a chain of cells, cell 0 being the
// newest entry. Push and pop shift the whole chain one place, clear only zeroes
// the fill count. Find and replace rotates the whole chain whatever the fill
// level: the chain rotates once around, one cell per cycle, every entry passing
// the comparator at the top cell, and the first hit from the newest end is
// rewritten as it wraps. One item is in the block at a time; the next item is
// taken as soon as the previous result has left or is leaving the output
// register. No clearing pass after reset: the store starts empty.
module lifo_stack_with_find_replace_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [31:0] req_value,
   input  wire logic [31:0] req_match_value,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [1:0]  rsp_status,
   output      logic [6:0]  rsp_entry_count
);
   import lifo_fr_pkg::*;

   cell_ctl_type cell_ctl;
   word_type     cell_q [DEPTH];

   // Sequencer
   lifo_fr_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_value       (req_value),
      .req_match_value (req_match_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .top_word        (cell_q[0]),
      .cell_ctl        (cell_ctl)
   );

   // Cell chain: upper neighbor is newer, lower neighbor is older
   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      word_type upper_word;
      word_type lower_word;

      if (gi == 0) begin : g_top
         assign upper_word = cell_ctl.push_word;
      end else begin : g_mid_up
         assign upper_word = cell_q[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_bottom
         assign lower_word = cell_ctl.wrap_word;
      end else begin : g_mid_dn
         assign lower_word = cell_q[gi+1];
      end

      lifo_fr_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .upper_word (upper_word),
         .lower_word (lower_word),
         .q_word     (cell_q[gi])
      );
   end

endmodule
`default_nettype wire

// ===== test/lifo_stack_with_find_replace_core_tb.sv =====
// Self-checking testbench for the LIFO stack core with find and replace.
`timescale 1ns / 100ps

module lifo_stack_with_find_replace_core_tb;
   import lifo_fr_pkg::*;

   // One awaited result, tagged with the command that caused it
   typedef struct {
      cmd_type           cmd;
      status_type        status;
      logic [ENTRY_CNT_W-1:0] count;
   } stack_outcome_type;

   // Shadow copy of the stack: predicts each outcome and checks the block against it
   class stack_shadow;
      word_type          slots [DEPTH];
      int                used;
      int                peak_used;
      int                errors;
      int                checked;
      int                status_seen [4];
      stack_outcome_type awaited [$];

      function new();
         used = 0;
         peak_used = 0;
         errors = 0;
         checked = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         foreach (slots[i]) slots[i] = '0;
      endfunction

      // sign-extend the 32-bit input word, keep the stored width
      function word_type widen(logic [31:0] raw);
         logic signed [63:0] ext;
         ext = {{32{raw[31]}}, raw};
         return ext[DATA_WIDTH-1:0];
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction

      // Run one accepted command on the shadow and queue its outcome
      function void apply_command(cmd_type cmd, logic [31:0] value, logic [31:0] match);
         stack_outcome_type o;
         word_type          v;
         word_type          m;
         bit                hit;
         int                i;
         v = widen(value);
         m = widen(match);
         o.cmd = cmd;
         o.status = STS_OK;
         case (cmd)
            CMD_PUSH: begin
               if (used >= DEPTH) begin
                  o.status = STS_FULL;
               end else begin
                  slots[used] = v;
                  used++;
               end
            end
            CMD_POP: begin
               if (used == 0) o.status = STS_EMPTY;
               else used--;
            end
            CMD_FIND: begin
               // newest entry first; only the first hit is rewritten
               hit = 1'b0;
               for (i = used - 1; i >= 0 && !hit; i--) begin
                  if (slots[i] == m) begin
                     slots[i] = v;
                     hit = 1'b1;
                  end
               end
               o.status = hit ? STS_OK : STS_NOT_FOUND;
            end
            default: begin
               used = 0;
            end
         endcase
         if (used > peak_used) peak_used = used;
         o.count = ENTRY_CNT_W'(used);
         awaited.push_back(o);
      endfunction

      // Compare one accepted result with the oldest awaited outcome
      function void check_result(logic [1:0] status, logic [ENTRY_CNT_W-1:0] count);
         stack_outcome_type o;
         checked++;
         if (status !== 2'bxx && !$isunknown(status)) status_seen[status]++;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: result with no command outstanding: status %0d count %0d",
                        $time, status, count);
            return;
         end
         o = awaited.pop_front();
         if (status !== o.status || count !== o.count) begin
            errors++;
            if (errors <= 10)
               $display("%0t: mismatch after %s: status exp %0d got %0d, count exp %0d got %0d",
                        $time, o.cmd.name(), o.status, status, o.count, count);
         end
      endfunction
   endclass

   localparam int RANDOM_ITEMS = 560;
   localparam int QUIET_TAIL   = 80;
   localparam int CYCLE_LIMIT  = 400000;

   typedef enum {EP_FILL, EP_DRAIN, EP_MIXED, EP_NOISE} episode_kind_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_command;
   logic [31:0] req_value;
   logic [31:0] req_match_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_entry_count;

   stack_shadow shadow;
   bit          idle_enabled;
   bit          quiet;
   int          items_sent;
   int          cycle_count;
   int          stall_left;
   logic [31:0] last_popped;

   lifo_stack_with_find_replace_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_value       (req_value),
      .req_match_value (req_match_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // cycle counter and watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results still awaited",
               cycle_count, shadow.outstanding());
      $display("lifo_stack_with_find_replace_core_tb: errors");
      $finish;
   end

   // result side: random stall bursts, none in the quiet tail
   initial begin
      rsp_stall = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (idle_enabled && !quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         shadow.check_result(rsp_status, rsp_entry_count);
   end

   // mix of random, small and extreme words so duplicates occur
   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return $urandom();
      if (r < 75) return 32'($signed($urandom_range(0, 8)) - 4);
      case ($urandom_range(0, 3))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // match word: mostly a stored entry, sometimes a popped one or noise
   function automatic logic [31:0] pick_match();
      int r;
      r = $urandom_range(0, 99);
      if (shadow.used > 0 && r < 60)
         return 32'(shadow.slots[$urandom_range(0, shadow.used - 1)]);
      if (r < 75) return last_popped;
      return pick_value();
   endfunction

   // Present one item at the falling edge and hold it until accepted
   task automatic send_item(input cmd_type cmd, input logic [31:0] value,
                            input logic [31:0] match);
      if (idle_enabled && !quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      if (cmd == CMD_POP && shadow.used > 0)
         last_popped = 32'(shadow.slots[shadow.used - 1]);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_value <= value;
      req_match_value <= match;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      shadow.apply_command(cmd, value, match);
      items_sent++;
      @(negedge clock);
   endtask

   initial begin
      episode_kind_type kind;
      int               episode;
      int               n;
      int               r;
      int               random_goal;

      shadow = new();
      cycle_count = 0;
      items_sent = 0;
      idle_enabled = 1'b1;
      quiet = 1'b0;
      last_popped = 32'h1234_5678;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_PUSH;
      req_value = '0;
      req_match_value = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty-store cases
      send_item(CMD_POP, 32'h0, 32'h0);
      send_item(CMD_FIND, 32'h1, 32'h0);
      send_item(CMD_CLEAR, 32'h0, 32'h0);
      // extreme words
      send_item(CMD_PUSH, 32'h8000_0000, 32'hFFFF_FFFF);
      send_item(CMD_PUSH, 32'h7FFF_FFFF, 32'h0);
      send_item(CMD_PUSH, 32'h0000_0000, 32'h8000_0000);
      send_item(CMD_PUSH, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      // hit on the oldest entry, then a miss
      send_item(CMD_FIND, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(CMD_FIND, 32'hAAAA_5555, 32'h1234_5678);
      // duplicates: only the newest copy is replaced
      send_item(CMD_PUSH, 32'd5, 32'h0);
      send_item(CMD_PUSH, 32'd5, 32'h0);
      send_item(CMD_FIND, 32'd9, 32'd5);
      send_item(CMD_POP, 32'h0, 32'h0);
      send_item(CMD_FIND, 32'd11, 32'd9);
      send_item(CMD_FIND, 32'd12, 32'd5);
      // popped word must no longer match
      send_item(CMD_POP, 32'h0, 32'h0);
      send_item(CMD_FIND, 32'h5555_AAAA, last_popped);
      send_item(CMD_FIND, 32'h0F0F_0F0F, 32'hFFFF_FFFF);
      // clear a non-empty store, then empty cases again
      send_item(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(CMD_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(CMD_FIND, 32'h0, 32'h0);
      send_item(CMD_PUSH, 32'h0, 32'hFFFF_FFFF);

      // random episodes: fills to full, drains to empty, mixed traffic, noise
      random_goal = items_sent + RANDOM_ITEMS;
      episode = 0;
      while (items_sent < random_goal) begin
         if (episode == 0) kind = EP_FILL;
         else if (episode == 1) kind = EP_DRAIN;
         else begin
            r = $urandom_range(0, 99);
            kind = r < 20 ? EP_FILL : r < 35 ? EP_DRAIN : r < 85 ? EP_MIXED : EP_NOISE;
         end
         quiet = (items_sent >= random_goal - QUIET_TAIL);
         idle_enabled = ($urandom_range(0, 3) != 0);
         case (kind)
            EP_FILL: begin
               while (shadow.used < DEPTH) begin
                  if ($urandom_range(0, 9) == 0) send_item(CMD_FIND, pick_value(), pick_match());
                  else send_item(CMD_PUSH, pick_value(), $urandom());
               end
               // pushes and one find on a full store
               repeat ($urandom_range(1, 3)) send_item(CMD_PUSH, pick_value(), $urandom());
               send_item(CMD_FIND, pick_value(), pick_match());
            end
            EP_DRAIN: begin
               while (shadow.used > 0) begin
                  if ($urandom_range(0, 9) == 0) send_item(CMD_FIND, pick_value(), pick_match());
                  else send_item(CMD_POP, $urandom(), $urandom());
               end
               repeat ($urandom_range(1, 2)) send_item(CMD_POP, $urandom(), $urandom());
            end
            EP_MIXED: begin
               n = $urandom_range(15, 30);
               repeat (n) begin
                  r = $urandom_range(0, 99);
                  if (r < 40) send_item(CMD_PUSH, pick_value(), $urandom());
                  else if (r < 65) send_item(CMD_POP, $urandom(), $urandom());
                  else if (r < 95) send_item(CMD_FIND, pick_value(), pick_match());
                  else send_item(CMD_CLEAR, $urandom(), $urandom());
               end
            end
            default: begin
               repeat ($urandom_range(2, 5))
                  send_item(cmd_type'($urandom_range(0, 3)), $urandom(), $urandom());
            end
         endcase
         episode++;
      end
      req_valid <= 1'b0;

      // drain outstanding results, then watch for strays
      while (shadow.outstanding() != 0) @(posedge clock);
      repeat (DEPTH + 16) @(posedge clock);

      $display("%0d commands, %0d results checked, deepest fill %0d of %0d",
               items_sent, shadow.checked, shadow.peak_used, DEPTH);
      $display("status seen: ok %0d, pop on empty %0d, push on full %0d, not found %0d",
               shadow.status_seen[STS_OK], shadow.status_seen[STS_EMPTY],
               shadow.status_seen[STS_FULL], shadow.status_seen[STS_NOT_FOUND]);
      if (shadow.errors == 0) begin
         $display("lifo_stack_with_find_replace_core_tb: clean");
      end else begin
         $display("%0d failures", shadow.errors);
         $display("lifo_stack_with_find_replace_core_tb: errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/lifo_fr_pkg.sv
rtl/lifo_fr_cell.sv
rtl/lifo_fr_ctrl.sv
rtl/lifo_stack_with_find_replace_core.sv
test/lifo_stack_with_find_replace_core_tb.sv
